[sv/assert_macros.svh]
// Assertion macros shared by the table RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CRIT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRIT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crit: next-cycle check failed");

`endif

[sv/crit_pkg.sv]
package crit_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ADDR_W      = 32;
    localparam int LEN_W       = 32;
    localparam int STATUS_W    = 2;

    // Reset value of the address mask register.
    localparam logic [ADDR_W-1:0] MASK_RESET = 32'h3FFF_FFFF;

    typedef enum logic
    {
        OP_REMEMBER   = 1'b0,
        OP_INVALIDATE = 1'b1
    } opcode_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STATUS_DONE    = 2'd0,
        STATUS_IGNORED = 2'd1,
        STATUS_FULL    = 2'd2
    } status_t;

    // What the datapath does with each entry read during a scan.
    typedef enum logic [1:0]
    {
        PROC_NONE   = 2'd0,
        PROC_REM    = 2'd1,
        PROC_MARK   = 2'd2,
        PROC_SEARCH = 2'd3
    } proc_t;

    // Which result is loaded into the output register.
    typedef enum logic [1:0]
    {
        RES_IGNORED  = 2'd0,
        RES_REMEMBER = 2'd1,
        RES_EMPTY    = 2'd2,
        RES_RETIRED  = 2'd3
    } res_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_ZERO,
        ST_REM_SCAN,
        ST_REM_DONE,
        ST_INV_MARK,
        ST_INV_CHECK,
        ST_INV_NONE,
        ST_INV_SEARCH,
        ST_INV_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic  in_ready;
        logic  load;
        logic  scan_start;
        logic  hit_clear;
        proc_t proc;
        logic  out_load;
        res_t  res;
        logic  rem_commit;
        logic  retire;
    } crit_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic    in_valid;
        logic    in_len_zero;
        opcode_t in_op;
        logic    scan_done;
        logic    hits_zero;
        logic    last_hit;
        logic    out_free;
    } crit_sts_t;

endpackage

[sv/crit_in_if.sv]
interface crit_in_if;

    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [crit_pkg::ADDR_W-1:0]   address;
    logic [crit_pkg::LEN_W-1:0]    length;

    modport source (output valid, output opcode, output address, output length, input ready);
    modport sink (input valid, input opcode, input address, input length, output ready);

endinterface

[sv/crit_out_if.sv]
interface crit_out_if;

    logic                          valid;
    logic                          ready;
    logic [crit_pkg::ADDR_W-1:0]   retired_address;
    logic                          retired_valid;
    logic [crit_pkg::STATUS_W-1:0] status;
    logic                          last;

    modport source
    (
        output valid, output retired_address, output retired_valid,
        output status, output last, input ready
    );
    modport sink
    (
        input valid, input retired_address, input retired_valid,
        input status, input last, output ready
    );

endinterface

[sv/crit_ram.sv]
module crit_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/crit_ctrl.sv]
module crit_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  crit_pkg::crit_sts_t sts,
    output crit_pkg::crit_cmd_t cmd
);

    crit_pkg::state_t state_reg;
    crit_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crit_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            crit_pkg::ST_IDLE:
            begin
                if (sts.in_valid)
                begin
                    if (sts.in_len_zero)
                        state_next = crit_pkg::ST_ZERO;
                    else if (sts.in_op == crit_pkg::OP_REMEMBER)
                        state_next = crit_pkg::ST_REM_SCAN;
                    else
                        state_next = crit_pkg::ST_INV_MARK;
                end
            end
            crit_pkg::ST_ZERO:
            begin
                if (sts.out_free)
                    state_next = crit_pkg::ST_IDLE;
            end
            crit_pkg::ST_REM_SCAN:
            begin
                if (sts.scan_done)
                    state_next = crit_pkg::ST_REM_DONE;
            end
            crit_pkg::ST_REM_DONE:
            begin
                if (sts.out_free)
                    state_next = crit_pkg::ST_IDLE;
            end
            crit_pkg::ST_INV_MARK:
            begin
                if (sts.scan_done)
                    state_next = crit_pkg::ST_INV_CHECK;
            end
            crit_pkg::ST_INV_CHECK:
            begin
                if (sts.hits_zero)
                    state_next = crit_pkg::ST_INV_NONE;
                else
                    state_next = crit_pkg::ST_INV_SEARCH;
            end
            crit_pkg::ST_INV_NONE:
            begin
                if (sts.out_free)
                    state_next = crit_pkg::ST_IDLE;
            end
            crit_pkg::ST_INV_SEARCH:
            begin
                if (sts.scan_done)
                    state_next = crit_pkg::ST_INV_EMIT;
            end
            crit_pkg::ST_INV_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (sts.last_hit)
                        state_next = crit_pkg::ST_IDLE;
                    else
                        state_next = crit_pkg::ST_INV_SEARCH;
                end
            end
            default:
            begin
                state_next = crit_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.in_ready   = 1'b0;
        cmd.load       = 1'b0;
        cmd.scan_start = 1'b0;
        cmd.hit_clear  = 1'b0;
        cmd.proc       = crit_pkg::PROC_NONE;
        cmd.out_load   = 1'b0;
        cmd.res        = crit_pkg::RES_IGNORED;
        cmd.rem_commit = 1'b0;
        cmd.retire     = 1'b0;
        case (state_reg)
            crit_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                cmd.load     = sts.in_valid;
                if (sts.in_valid && !sts.in_len_zero)
                begin
                    cmd.scan_start = 1'b1;
                    cmd.hit_clear  = (sts.in_op == crit_pkg::OP_INVALIDATE);
                end
            end
            crit_pkg::ST_ZERO:
            begin
                cmd.out_load = sts.out_free;
                cmd.res      = crit_pkg::RES_IGNORED;
            end
            crit_pkg::ST_REM_SCAN:
            begin
                cmd.proc = crit_pkg::PROC_REM;
            end
            crit_pkg::ST_REM_DONE:
            begin
                cmd.out_load   = sts.out_free;
                cmd.res        = crit_pkg::RES_REMEMBER;
                cmd.rem_commit = sts.out_free;
            end
            crit_pkg::ST_INV_MARK:
            begin
                cmd.proc = crit_pkg::PROC_MARK;
            end
            crit_pkg::ST_INV_CHECK:
            begin
                cmd.scan_start = !sts.hits_zero;
            end
            crit_pkg::ST_INV_NONE:
            begin
                cmd.out_load = sts.out_free;
                cmd.res      = crit_pkg::RES_EMPTY;
            end
            crit_pkg::ST_INV_SEARCH:
            begin
                cmd.proc = crit_pkg::PROC_SEARCH;
            end
            crit_pkg::ST_INV_EMIT:
            begin
                cmd.out_load   = sts.out_free;
                cmd.res        = crit_pkg::RES_RETIRED;
                cmd.retire     = sts.out_free;
                cmd.scan_start = sts.out_free && !sts.last_hit;
            end
            default:
            begin
                cmd.in_ready = 1'b0;
            end
        endcase
    end

endmodule

[sv/crit_dp.sv]
`include "assert_macros.svh"

module crit_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    crit_in_if.sink                       in_ch,
    crit_out_if.source                    out_ch,
    input  logic                          cfg_wr_en,
    input  logic [crit_pkg::ADDR_W-1:0]   cfg_wr_data,
    input  crit_pkg::crit_cmd_t           cmd,
    output crit_pkg::crit_sts_t           sts
);

    localparam int IW = crit_pkg::IDX_W;
    localparam int CW = crit_pkg::CNT_W;
    localparam int AW = crit_pkg::ADDR_W;
    localparam int LW = crit_pkg::LEN_W;
    localparam int D  = crit_pkg::TABLE_DEPTH;

    // Configuration and the item being worked on.
    logic [AW-1:0] mask_reg;
    logic [AW-1:0] canon_reg;
    logic [LW-1:0] len_reg;
    logic [AW:0]   dend_reg;
    logic [AW-1:0] canon_in;

    // Scan address generator and read pipeline.
    logic          scanning_reg;
    logic [IW-1:0] issue_idx_reg;
    logic          rd_vld_reg;
    logic [IW-1:0] rd_idx_reg;
    logic [AW-1:0] start_q;
    logic [LW-1:0] size_q;

    // Per-entry flags and hit count.
    logic [D-1:0]  valid_reg;
    logic [D-1:0]  valid_next;
    logic [D-1:0]  hit_reg;
    logic [D-1:0]  hit_next;
    logic [CW-1:0] hit_cnt_reg;
    logic [CW-1:0] hit_cnt_next;

    // Scan results.
    logic          match_found_reg;
    logic [IW-1:0] match_slot_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_slot_reg;
    logic          best_found_reg;
    logic [IW-1:0] best_slot_reg;
    logic [AW-1:0] best_start_reg;

    // Output register.
    logic          out_valid_reg;
    logic [AW-1:0] out_addr_reg;
    logic          out_rvalid_reg;
    logic [1:0]    out_status_reg;
    logic          out_last_reg;
    logic          out_free;

    // Entry test terms.
    logic          cur_valid;
    logic          cur_match;
    logic          cur_overlap;
    logic          cur_better;
    logic [AW:0]   cur_end;
    logic          ram_wr_en;
    logic [IW-1:0] ram_wr_addr;

    assign canon_in = in_ch.address & mask_reg;
    assign in_ch.ready = cmd.in_ready;

    // Mask register and item capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= crit_pkg::MASK_RESET;
        end
        else if (cfg_wr_en)
        begin
            mask_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            canon_reg <= canon_in;
            len_reg   <= in_ch.length;
            dend_reg  <= {1'b0, canon_in} + {1'b0, in_ch.length};
        end
    end

    // Scan address generator: one entry a cycle, with its read data in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scanning_reg  <= 1'b0;
            issue_idx_reg <= '0;
            rd_vld_reg    <= 1'b0;
            rd_idx_reg    <= '0;
        end
        else
        begin
            rd_vld_reg <= scanning_reg;
            rd_idx_reg <= issue_idx_reg;
            if (cmd.scan_start)
            begin
                scanning_reg  <= 1'b1;
                issue_idx_reg <= '0;
            end
            else if (scanning_reg)
            begin
                issue_idx_reg <= issue_idx_reg + IW'(1);
                if (issue_idx_reg == IW'(D - 1))
                    scanning_reg <= 1'b0;
            end
        end
    end

    // Start and size stores.
    assign ram_wr_en   = cmd.rem_commit && (match_found_reg || free_found_reg);
    assign ram_wr_addr = match_found_reg ? match_slot_reg : free_slot_reg;

    crit_ram #(.WIDTH(AW), .DEPTH(D)) u_start_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (canon_reg),
        .rd_en   (scanning_reg),
        .rd_addr (issue_idx_reg),
        .rd_data (start_q)
    );

    crit_ram #(.WIDTH(LW), .DEPTH(D)) u_size_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (len_reg),
        .rd_en   (scanning_reg),
        .rd_addr (issue_idx_reg),
        .rd_data (size_q)
    );

    // Tests on the entry just read.
    always_comb
    begin
        cur_valid   = valid_reg[rd_idx_reg];
        cur_end     = {1'b0, start_q} + {1'b0, size_q};
        cur_match   = cur_valid && (start_q == canon_reg);
        cur_overlap = cur_valid && (dend_reg > {1'b0, start_q})
                      && ({1'b0, canon_reg} < cur_end);
        cur_better  = hit_reg[rd_idx_reg] && (!best_found_reg || (start_q < best_start_reg));
    end

    // Valid and hit flags with the hit count.
    always_comb
    begin
        valid_next   = valid_reg;
        hit_next     = hit_reg;
        hit_cnt_next = hit_cnt_reg;
        if (cmd.hit_clear)
        begin
            hit_next     = '0;
            hit_cnt_next = '0;
        end
        if (rd_vld_reg && (cmd.proc == crit_pkg::PROC_MARK) && cur_overlap)
        begin
            hit_next[rd_idx_reg] = 1'b1;
            hit_cnt_next         = hit_cnt_reg + CW'(1);
        end
        if (cmd.rem_commit && !match_found_reg && free_found_reg)
        begin
            valid_next[free_slot_reg] = 1'b1;
        end
        if (cmd.retire)
        begin
            valid_next[best_slot_reg] = 1'b0;
            hit_next[best_slot_reg]   = 1'b0;
            hit_cnt_next              = hit_cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            hit_reg     <= '0;
            hit_cnt_reg <= '0;
        end
        else
        begin
            valid_reg   <= valid_next;
            hit_reg     <= hit_next;
            hit_cnt_reg <= hit_cnt_next;
        end
    end

    // Scan accumulators: matching slot, first free slot, lowest hit start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else if (rd_vld_reg)
        begin
            if ((cmd.proc == crit_pkg::PROC_REM) && cur_match)
                match_found_reg <= 1'b1;
            if ((cmd.proc == crit_pkg::PROC_REM) && !cur_valid)
                free_found_reg <= 1'b1;
            if ((cmd.proc == crit_pkg::PROC_SEARCH) && cur_better)
                best_found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            if ((cmd.proc == crit_pkg::PROC_REM) && cur_match)
                match_slot_reg <= rd_idx_reg;
            if ((cmd.proc == crit_pkg::PROC_REM) && !cur_valid && !free_found_reg)
                free_slot_reg <= rd_idx_reg;
            if ((cmd.proc == crit_pkg::PROC_SEARCH) && cur_better)
            begin
                best_slot_reg  <= rd_idx_reg;
                best_start_reg <= start_q;
            end
        end
    end

    // Output register.
    assign out_free = !out_valid_reg || out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.res)
                crit_pkg::RES_IGNORED:
                begin
                    out_addr_reg   <= '0;
                    out_rvalid_reg <= 1'b0;
                    out_status_reg <= crit_pkg::STATUS_IGNORED;
                    out_last_reg   <= 1'b1;
                end
                crit_pkg::RES_REMEMBER:
                begin
                    out_addr_reg   <= '0;
                    out_rvalid_reg <= 1'b0;
                    out_status_reg <= (!match_found_reg && !free_found_reg)
                                      ? crit_pkg::STATUS_FULL : crit_pkg::STATUS_DONE;
                    out_last_reg   <= 1'b1;
                end
                crit_pkg::RES_RETIRED:
                begin
                    out_addr_reg   <= best_start_reg;
                    out_rvalid_reg <= 1'b1;
                    out_status_reg <= crit_pkg::STATUS_DONE;
                    out_last_reg   <= (hit_cnt_reg == CW'(1));
                end
                default:
                begin
                    out_addr_reg   <= '0;
                    out_rvalid_reg <= 1'b0;
                    out_status_reg <= crit_pkg::STATUS_DONE;
                    out_last_reg   <= 1'b1;
                end
            endcase
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.retired_address = out_addr_reg;
    assign out_ch.retired_valid   = out_rvalid_reg;
    assign out_ch.status          = out_status_reg;
    assign out_ch.last            = out_last_reg;

    // Status to the controller.
    always_comb
    begin
        sts.in_valid    = in_ch.valid;
        sts.in_len_zero = (in_ch.length == '0);
        sts.in_op       = crit_pkg::opcode_t'(in_ch.opcode);
        sts.scan_done   = rd_vld_reg && (rd_idx_reg == IW'(D - 1));
        sts.hits_zero   = (hit_cnt_reg == '0);
        sts.last_hit    = (hit_cnt_reg == CW'(1));
        sts.out_free    = out_free;
    end

    // Checks on the table bookkeeping.
    `CRIT_ASSERT_IMPL(a_hit_implies_valid, 1'b1, (hit_reg & ~valid_reg) == '0)
    `CRIT_ASSERT_IMPL(a_hit_count, 1'b1, $countones(hit_reg) == int'(hit_cnt_reg))
    `CRIT_ASSERT_IMPL(a_retire_hit, cmd.retire, best_found_reg && hit_reg[best_slot_reg])
    `CRIT_ASSERT_NEXT(a_load_shown, cmd.out_load && out_free, out_valid_reg)

endmodule

[sv/copy_range_invalidation_table_core.sv]
// Copy-destination range table.
// Input channel in_ch carries opcode, address and length; an item is taken
// when valid and ready are both high. Opcode remember stores or replaces a
// range size at the masked start address; opcode invalidate removes every
// stored range that overlaps the dirty range. Result channel out_ch returns
// retired_address, retired_valid, status and last; last marks the final
// result of an item. Removed starts come out in ascending address order.
// The address mask is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// A zero-length item needs no scan, and a remember needs one full scan of the
// table. An invalidate takes one scan to mark overlapping entries; with no
// overlap its result follows that scan. Otherwise one scan per removed entry
// finds the lowest start. Every scan reads the entries through the single
// read port of the start and size memories. Items are taken one at a time;
// ready is high only when the previous item has finished, though its last
// result may still wait in the output register. Reset empties the table and
// sets the mask to 0x3FFFFFFF. A stalled receiver holds the result in the
// output register and the scan waits behind it.
module copy_range_invalidation_table_core (
    input  logic                        clk,
    input  logic                        rst_n,
    crit_in_if.sink                     in_ch,
    crit_out_if.source                  out_ch,
    input  logic                        cfg_wr_en,
    input  logic [crit_pkg::ADDR_W-1:0] cfg_wr_data
);

    crit_pkg::crit_cmd_t cmd;
    crit_pkg::crit_sts_t sts;

    // Sequencer.
    crit_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Table storage, scan and output register.
    crit_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule
